// ===== rtl/core/sip_pkg.sv =====
`timescale 1ns / 1ps

package sip_pkg;

	// initialization constants for the four lanes
	localparam logic [63:0] INIT_V0 = 64'h736f6d6570736575;
	localparam logic [63:0] INIT_V1 = 64'h646f72616e646f6d;
	localparam logic [63:0] INIT_V2 = 64'h6c7967656e657261;
	localparam logic [63:0] INIT_V3 = 64'h7465646279746573;
	localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;
	localparam logic [7:0]  WORD_BYTES = 8'd8;

	typedef struct packed {
		logic [63:0] v0;
		logic [63:0] v1;
		logic [63:0] v2;
		logic [63:0] v3;
	} lanes_t;

	// one message word as it enters the core
	typedef struct packed {
		logic [63:0] data_word;
		logic [3:0]  byte_count;
		logic        last;
	} item_t;

	// final-word handoff to the finalization pipe
	typedef struct packed {
		logic        vld;
		lanes_t      lanes;
		logic [63:0] tail;
	} fin_req_t;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
		return (x << r) | (x >> (64 - r));
	endfunction

	// one mixing round: two levels of 64-bit adds
	function automatic lanes_t sip_round(input lanes_t l);
		lanes_t r;
		r = l;
		r.v0 = r.v0 + r.v1;
		r.v1 = rotl(r.v1, 13) ^ r.v0;
		r.v0 = rotl(r.v0, 32);
		r.v2 = r.v2 + r.v3;
		r.v3 = rotl(r.v3, 16) ^ r.v2;
		r.v2 = r.v2 + r.v1;
		r.v1 = rotl(r.v1, 17) ^ r.v2;
		r.v2 = rotl(r.v2, 32);
		r.v0 = r.v0 + r.v3;
		r.v3 = rotl(r.v3, 21) ^ r.v0;
		return r;
	endfunction

	function automatic lanes_t sip_absorb(input lanes_t l, input logic [63:0] m);
		lanes_t r;
		r = l;
		r.v3 = r.v3 ^ m;
		r = sip_round(r);
		r.v0 = r.v0 ^ m;
		return r;
	endfunction

	function automatic lanes_t sip_init(input logic [63:0] seed);
		lanes_t r;
		r.v0 = INIT_V0 ^ seed;
		r.v1 = INIT_V1 ^ ~seed;
		r.v2 = INIT_V2 ^ seed;
		r.v3 = INIT_V3 ^ ~seed;
		return r;
	endfunction

endpackage

// ===== rtl/core/sip_absorb.sv =====
`timescale 1ns / 1ps

module sip_absorb (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [63:0]       seed,
	input  logic              item_vld,
	input  sip_pkg::item_t    item,
	output logic              item_stall,
	output sip_pkg::fin_req_t fin_req,
	input  logic              fin_rdy
);

	sip_pkg::lanes_t lanes_q;
	logic [7:0]      len_q;
	logic            open_q;

	sip_pkg::lanes_t start_lanes;
	sip_pkg::lanes_t absorbed;
	logic [7:0]      start_len;
	logic [7:0]      new_len;
	logic            full_word;
	logic [63:0]     masked;
	logic            adv;

	// a message starts from the seed when none is open
	assign start_lanes = open_q ? lanes_q : sip_pkg::sip_init(seed);
	assign start_len   = open_q ? len_q : 8'd0;

	// non-final words are always full; counts of 8 and above count as 8
	assign full_word = !item.last || item.byte_count[3];
	assign absorbed  = sip_pkg::sip_absorb(start_lanes, item.data_word);
	assign new_len   = start_len + (full_word ? sip_pkg::WORD_BYTES
		: {5'd0, item.byte_count[2:0]});

	// keep only the valid low bytes of a short final word
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			masked[8*i +: 8] = (i < int'(item.byte_count[2:0])) ?
				item.data_word[8*i +: 8] : 8'd0;
		end
	end

	// final words wait for room in the finalization pipe
	assign adv        = item_vld && (!item.last || fin_rdy);
	assign item_stall = item_vld && !adv;

	assign fin_req.vld   = item_vld && item.last;
	assign fin_req.lanes = full_word ? absorbed : start_lanes;
	assign fin_req.tail  = (full_word ? 64'd0 : masked) | {new_len, 56'd0};

	// lane state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			len_q  <= 8'd0;
		end else if (adv) begin
			open_q <= !item.last;
			len_q  <= new_len;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && !item.last) begin
			lanes_q <= absorbed;
		end
	end

endmodule

// ===== rtl/core/sip_finish.sv =====
`timescale 1ns / 1ps

module sip_finish (
	input  logic              clk,
	input  logic              arst_n,
	input  sip_pkg::fin_req_t fin_req,
	output logic              fin_rdy,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [63:0]       hash_value
);

	sip_pkg::lanes_t lanes_s2;
	logic [63:0]     tail_s2;
	logic            vld_s2;
	sip_pkg::lanes_t lanes_s3;
	logic            vld_s3;
	logic [63:0]     hash_q;
	logic            out_vld_q;

	sip_pkg::lanes_t tail_mix;
	sip_pkg::lanes_t last_mix;
	logic            rdy_out;
	logic            rdy_s3;

	// stage readiness, back from the output
	assign rdy_out = !out_vld_q || !out_stall;
	assign rdy_s3  = !vld_s3 || rdy_out;
	assign fin_rdy = !vld_s2 || rdy_s3;

	// tail absorb and finalization marker, then the last round
	always_comb begin
		tail_mix    = sip_pkg::sip_absorb(lanes_s2, tail_s2);
		tail_mix.v2 = tail_mix.v2 ^ sip_pkg::FINAL_XOR;
		last_mix    = sip_pkg::sip_round(lanes_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (fin_rdy) begin
				vld_s2 <= fin_req.vld;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_out) begin
				out_vld_q <= vld_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_rdy && fin_req.vld) begin
			lanes_s2 <= fin_req.lanes;
			tail_s2  <= fin_req.tail;
		end
		if (rdy_s3 && vld_s2) begin
			lanes_s3 <= tail_mix;
		end
		if (rdy_out && vld_s3) begin
			hash_q <= last_mix.v1 ^ last_mix.v2 ^ last_mix.v3;
		end
	end

	assign out_valid  = out_vld_q;
	assign hash_value = hash_q;

endmodule

// ===== rtl/core/siphash_1_1_byte_hash_core.sv =====
`timescale 1ns / 1ps

// Channel   Signals                                   Direction
// input     in_valid, in_stall, data_word,            beat in
//           byte_count, last
// output    out_valid, out_stall, hash_value          beat out
// config    hash_seed_wr_en, hash_seed_wr_data        write only
//
// One word beat per cycle while in_stall is low. Each word is held in the
// input register, and each full word runs one round in the lane loop; a final
// word runs two more rounds in the finalization pipe; the hash is registered.
// Reset clears the seed, the open-message flag and all valid flags.
// out_stall backs up through the finalization pipe; non-final words keep
// flowing until a final word finds that pipe full.

module siphash_1_1_byte_hash_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        hash_seed_wr_en,
	input  logic [63:0] hash_seed_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] hash_value
);

	logic [63:0]       seed_q;
	sip_pkg::item_t    item_s1;
	logic              vld_s1;
	logic              item_stall;
	sip_pkg::fin_req_t fin_req;
	logic              fin_rdy;

	// seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 64'd0;
		end else if (hash_seed_wr_en) begin
			seed_q <= hash_seed_wr_data;
		end
	end

	// input register
	assign in_stall = item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!item_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !item_stall) begin
			item_s1.data_word  <= data_word;
			item_s1.byte_count <= byte_count;
			item_s1.last       <= last;
		end
	end

	sip_absorb u_absorb (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed       (seed_q),
		.item_vld   (vld_s1),
		.item       (item_s1),
		.item_stall (item_stall),
		.fin_req    (fin_req),
		.fin_rdy    (fin_rdy)
	);

	sip_finish u_finish (
		.clk        (clk),
		.arst_n     (arst_n),
		.fin_req    (fin_req),
		.fin_rdy    (fin_rdy),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value)
	);

endmodule
